// File: sv/tbrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared widths, codes and types of the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  localparam int RATE_W     = 20;
  localparam int PERMIT_W   = 32;
  localparam int IVAL_W     = 36;
  localparam int TIME_W     = 48;
  localparam int WAIT_W     = 21;
  localparam int OUTCOME_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;
  localparam int FRAC_W     = 16;
  localparam int ALU_W      = 64;
  localparam int DIV_STEPS  = TIME_W + FRAC_W;
  localparam int MUL_STEPS  = RATE_W;
  localparam int CNT_W      = 6;

  localparam logic [RATE_W-1:0]   RATE_RESET     = 20'd1000;
  localparam logic [PERMIT_W-1:0] PERMITS_RESET  = 32'd1000;
  localparam logic [IVAL_W-1:0]   INTERVAL_RESET = 36'd65536000;
  localparam logic [TIME_W-1:0]   TIME_MAX       = {TIME_W{1'b1}};
  localparam logic [WAIT_W-1:0]   WAIT_MAX       = {WAIT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RATE        = 2'd0,
    REG_MAX_PERMITS     = 2'd1,
    REG_PERMIT_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_ACQUIRE  = 1'b0,
    CMD_ROLLBACK = 1'b1
  } command_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_GRANTED = 2'd0,
    OUT_WAIT    = 2'd1,
    OUT_REFUSED = 2'd2
  } outcome_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_REFILL,
    ST_ADVANCE,
    ST_CHECK,
    ST_MUL,
    ST_DEBT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0]   max_rate;
    logic [PERMIT_W-1:0] max_permits;
    logic [IVAL_W-1:0]   permit_interval;
  } cfg_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [WAIT_W-1:0]    wait_us;
  } result_t;

endpackage
`default_nettype wire

// File: sv/tbrl_addsub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbrl_addsub
// Shared 64-bit adder/subtractor used by the division, refill, advance, multiply and debt steps of the sequencer.
// ----------------------------------------------------------------------------
module tbrl_addsub (
  input  wire logic [tbrl_pkg::ALU_W-1:0] a,
  input  wire logic [tbrl_pkg::ALU_W-1:0] b,
  input  wire tbrl_pkg::alu_op_t          op,
  output logic      [tbrl_pkg::ALU_W-1:0] result,
  output logic                            carry
);
  import tbrl_pkg::*;

  logic [ALU_W:0] full;

  // subtract as a + ~b + 1, carry set means no borrow
  always_comb begin
    if (op == ALU_SUB) begin
      full = {1'b0, a} + {1'b0, ~b} + {{ALU_W{1'b0}}, 1'b1};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign result = full[ALU_W-1:0];
  assign carry  = full[ALU_W];

endmodule
`default_nettype wire

// File: sv/tbrl_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbrl_core
// Sequencer and bucket state; refill division and debt multiply run one bit
// per cycle through the shared adder.
// ----------------------------------------------------------------------------
module tbrl_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [tbrl_pkg::TIME_W-1:0]   in_now,
  input  wire logic [tbrl_pkg::PERMIT_W-1:0] in_req,
  input  wire tbrl_pkg::cfg_t                cfg,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output tbrl_pkg::result_t                  res
);
  import tbrl_pkg::*;

  state_t state, state_next;

  logic                cmd;
  logic [TIME_W-1:0]   now;
  logic [PERMIT_W-1:0] req;
  logic [PERMIT_W-1:0] stored, stored_next;
  logic [TIME_W-1:0]   last, last_next;
  logic [ALU_W-1:0]    dvd, dvd_next;
  logic [IVAL_W-1:0]   rem, rem_next;
  logic [TIME_W-1:0]   elapsed, elapsed_next;
  logic [55:0]         acc, acc_next;
  logic [55:0]         mcand, mcand_next;
  logic [RATE_W-1:0]   mplier, mplier_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  result_t             res_next;

  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  alu_op_t          alu_op;
  logic             alu_carry;

  logic [IVAL_W-1:0]   iv;
  logic [IVAL_W:0]     shifted;
  logic [PERMIT_W:0]   sum33;
  logic [PERMIT_W:0]   deficit;
  logic [TIME_W-1:0]   wait_diff;

  tbrl_addsub u_addsub (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .result (alu_res),
    .carry  (alu_carry)
  );

  // a zero interval counts as one
  assign iv = (cfg.permit_interval == '0) ? {{(IVAL_W-1){1'b0}}, 1'b1} : cfg.permit_interval;

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      stored <= '0;
      last   <= '0;
    end else begin
      state  <= state_next;
      stored <= stored_next;
      last   <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_cmd;
      now <= in_now;
      req <= in_req;
    end
    dvd     <= dvd_next;
    rem     <= rem_next;
    elapsed <= elapsed_next;
    acc     <= acc_next;
    mcand   <= mcand_next;
    mplier  <= mplier_next;
    cnt     <= cnt_next;
    res     <= res_next;
  end

  always_comb begin
    state_next   = state;
    stored_next  = stored;
    last_next    = last;
    dvd_next     = dvd;
    rem_next     = rem;
    elapsed_next = elapsed;
    acc_next     = acc;
    mcand_next   = mcand;
    mplier_next  = mplier;
    cnt_next     = cnt;
    res_next     = res;
    alu_a        = '0;
    alu_b        = '0;
    alu_op       = ALU_ADD;
    shifted      = {rem, dvd[ALU_W-1]};
    sum33        = {1'b0, stored} + {1'b0, req};
    deficit      = {1'b0, req} - {1'b0, stored};
    wait_diff    = last - now;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_next.outcome = OUT_GRANTED;
        res_next.wait_us = '0;
        if (cmd == CMD_ROLLBACK) begin
          stored_next = (sum33 < {1'b0, cfg.max_permits}) ? sum33[PERMIT_W-1:0]
                                                           : cfg.max_permits;
          state_next  = ST_FINISH;
        end else if (stored > req) begin
          stored_next = stored - req;
          state_next  = ST_FINISH;
        end else if (now > last) begin
          elapsed_next = now - last;
          dvd_next     = {now - last, {FRAC_W{1'b0}}};
          rem_next     = '0;
          cnt_next     = CNT_W'(DIV_STEPS - 1);
          state_next   = ST_DIV;
        end else begin
          state_next = ST_CHECK;
        end
      end

      // restoring division, quotient shifts into the dividend register
      ST_DIV: begin
        alu_a    = {{(ALU_W-IVAL_W-1){1'b0}}, shifted};
        alu_b    = {{(ALU_W-IVAL_W){1'b0}}, iv};
        alu_op   = ALU_SUB;
        rem_next = alu_carry ? alu_res[IVAL_W-1:0] : shifted[IVAL_W-1:0];
        dvd_next = {dvd[ALU_W-2:0], alu_carry};
        if (cnt == '0) begin
          state_next = ST_REFILL;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end

      // time consumed by the refill is (elapsed << 16) - remainder
      ST_REFILL: begin
        alu_a  = {elapsed, {FRAC_W{1'b0}}};
        alu_b  = {{(ALU_W-IVAL_W){1'b0}}, rem};
        alu_op = ALU_SUB;
        sum33  = {1'b0, stored} + {1'b0, dvd[PERMIT_W-1:0]};
        if ((dvd[ALU_W-1:PERMIT_W] != '0) || (sum33 >= {1'b0, cfg.max_permits})) begin
          stored_next = cfg.max_permits;
          last_next   = now;
          state_next  = ST_CHECK;
        end else begin
          stored_next  = sum33[PERMIT_W-1:0];
          elapsed_next = alu_res[ALU_W-1:FRAC_W];
          state_next   = ST_ADVANCE;
        end
      end

      // never passes now, so no saturation here
      ST_ADVANCE: begin
        alu_a      = {{(ALU_W-TIME_W){1'b0}}, last};
        alu_b      = {{(ALU_W-TIME_W){1'b0}}, elapsed};
        last_next  = alu_res[TIME_W-1:0];
        state_next = ST_CHECK;
      end

      ST_CHECK: begin
        if (last > now) begin
          res_next.outcome = OUT_WAIT;
          res_next.wait_us = (wait_diff[TIME_W-1:WAIT_W] != '0) ? WAIT_MAX
                                                               : wait_diff[WAIT_W-1:0];
          state_next       = ST_FINISH;
        end else if (!deficit[PERMIT_W] &&
                     (deficit[PERMIT_W-1:0] >= {{(PERMIT_W-RATE_W){1'b0}}, cfg.max_rate})) begin
          res_next.outcome = OUT_REFUSED;
          res_next.wait_us = {{(WAIT_W-1){1'b0}}, 1'b1};
          state_next       = ST_FINISH;
        end else if (req > stored) begin
          mplier_next = deficit[RATE_W-1:0];
          acc_next    = '0;
          mcand_next  = {{(56-IVAL_W){1'b0}}, iv};
          cnt_next    = CNT_W'(MUL_STEPS - 1);
          state_next  = ST_MUL;
        end else begin
          stored_next = stored - req;
          state_next  = ST_FINISH;
        end
      end

      // shift-add multiply of deficit by interval
      ST_MUL: begin
        alu_a = {{(ALU_W-56){1'b0}}, acc};
        alu_b = {{(ALU_W-56){1'b0}}, mcand};
        if (mplier[0]) begin
          acc_next = alu_res[55:0];
        end
        mcand_next  = {mcand[54:0], 1'b0};
        mplier_next = {1'b0, mplier[RATE_W-1:1]};
        if (cnt == '0) begin
          state_next = ST_DEBT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end

      ST_DEBT: begin
        alu_a       = {{(ALU_W-TIME_W){1'b0}}, last};
        alu_b       = {{(ALU_W-40){1'b0}}, acc[55:FRAC_W]};
        last_next   = (alu_res[ALU_W-1:TIME_W] != '0) ? TIME_MAX : alu_res[TIME_W-1:0];
        stored_next = '0;
        state_next  = ST_FINISH;
      end

      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/token_bucket_rate_limiter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_top
// Token bucket rate limiter with borrowing, stream in and stream out.
// ----------------------------------------------------------------------------
// One word at a time: s_tready is high only while the sequencer is idle. A
// rollback or an acquire served from stored permits goes from decide to the
// result, and an acquire that checks the bucket without a refill passes the
// check step first. An acquire that refills adds the bit-serial refill
// division (one quotient bit per cycle through the shared 64-bit adder) and
// the refill step, the time advance unless the bucket fills, and the
// bit-serial debt multiply and debt step when permits are borrowed. The
// result sits in an output register, so the next word is taken while it waits.
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [79:0]                     s_tdata,   // now_us, required_permits
  input  wire logic                            s_tuser,   // command
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [23:0]                     m_tdata,   // wait_us, zero pad
  output logic      [1:0]                      m_tuser,   // outcome
  input  wire logic                            cfg_we,
  input  wire logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tbrl_pkg::*;

  cfg_t    cfg;
  result_t res, out_word;
  logic    res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_rate        <= RATE_RESET;
      cfg.max_permits     <= PERMITS_RESET;
      cfg.permit_interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_RATE:        cfg.max_rate        <= cfg_data[RATE_W-1:0];
        REG_MAX_PERMITS:     cfg.max_permits     <= cfg_data[PERMIT_W-1:0];
        REG_PERMIT_INTERVAL: cfg.permit_interval <= cfg_data[IVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tbrl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_now    (s_tdata[TIME_W-1:0]),
    .in_req    (s_tdata[TIME_W+PERMIT_W-1:TIME_W]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees the sequencer as soon as the word is handed over
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign m_tdata = {3'b000, out_word.wait_us};
  assign m_tuser = out_word.outcome;

endmodule
`default_nettype wire

// File: dv/tb_token_bucket_rate_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_bucket_rate_limiter_top
// Self-checking bench for the token bucket rate limiter. A bit-accurate
// bucket model in the bench predicts outcome and wait for every accepted
// request word. Directed tests cover each corner of the bucket, then timed
// request sequences run under random limiter settings. Random idle gaps
// and stalls are used on both streams, including one long output stall.
// ----------------------------------------------------------------------------
module tb_token_bucket_rate_limiter_top;
  import tbrl_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int MAX_GAP        = 12;
  localparam int SETTLE_CYCLES  = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 160;
  localparam int STALL_WORDS    = 24;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [79:0]           s_tdata   = '0;   // now_us, required_permits
  logic                  s_tuser   = 1'b0; // command
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;          // wait_us, zero pad
  logic [1:0]            m_tuser;          // outcome
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // bucket model: limiter settings and bucket state
  logic [RATE_W-1:0]   lim_rate     = RATE_RESET;
  logic [PERMIT_W-1:0] lim_cap      = PERMITS_RESET;
  logic [IVAL_W-1:0]   lim_interval = INTERVAL_RESET;
  logic [63:0]         bkt_permits  = '0;
  logic [63:0]         bkt_time     = '0;

  result_t     pending_verdicts[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          fast_mode    = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [47:0] seq_time     = '0;

  token_bucket_rate_limiter_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [63:0] push_time(input logic [63:0] t, input logic [63:0] delta);
    logic [63:0] top;
    begin
      top = {16'd0, TIME_MAX};
      push_time = (delta >= top - t) ? top : t + delta;
    end
  endfunction

  // one request against the bucket model, returns the expected verdict
  task automatic bucket_serve(input command_t cmd, input logic [47:0] now,
                              input logic [31:0] req, output result_t verdict);
    logic [63:0] now64, req64, cap64, iv, elapsed, refill_cnt, sum, lag, debt;
    outcome_t    oc;
    logic [63:0] wt;
    begin
      now64 = {16'd0, now};
      req64 = {32'd0, req};
      cap64 = {32'd0, lim_cap};
      iv    = (lim_interval == '0) ? 64'd1 : {28'd0, lim_interval};
      oc    = OUT_GRANTED;
      wt    = '0;
      if (cmd == CMD_ROLLBACK) begin
        sum = bkt_permits + req64;
        bkt_permits = (sum < cap64) ? sum : cap64;
      end else if (bkt_permits > req64) begin
        bkt_permits = bkt_permits - req64;
      end else begin
        if (now64 > bkt_time) begin
          elapsed    = now64 - bkt_time;
          refill_cnt = (elapsed << FRAC_W) / iv;
          sum        = bkt_permits + refill_cnt;
          if (sum < bkt_permits) sum = '1;
          bkt_permits = (sum < cap64) ? sum : cap64;
          if (bkt_permits == cap64) bkt_time = now64;
          else bkt_time = push_time(bkt_time, (refill_cnt * iv) >> FRAC_W);
        end
        if (bkt_time > now64) begin
          oc  = OUT_WAIT;
          lag = bkt_time - now64;
          wt  = (lag > {43'd0, WAIT_MAX}) ? {43'd0, WAIT_MAX} : lag;
        end else if (req64 >= bkt_permits && req64 - bkt_permits >= {44'd0, lim_rate}) begin
          oc = OUT_REFUSED;
          wt = 64'd1;
        end else if (req64 > bkt_permits) begin
          // borrow ahead: debt moves the update time forward
          debt        = ((req64 - bkt_permits) * iv) >> FRAC_W;
          bkt_permits = '0;
          bkt_time    = push_time(bkt_time, debt);
        end else begin
          bkt_permits = bkt_permits - req64;
        end
      end
      verdict.outcome = oc;
      verdict.wait_us = wt[WAIT_W-1:0];
    end
  endtask

  // request and result monitor
  always @(posedge clk) begin
    result_t got, want, verdict;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.outcome = m_tuser;
        got.wait_us = m_tdata[WAIT_W-1:0];
        if (pending_verdicts.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("limiter: unexpected result word, outcome %0d wait %0d",
                     got.outcome, got.wait_us);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.outcome !== want.outcome || got.wait_us !== want.wait_us) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("limiter: mismatch, expected outcome %0d wait %0d, got outcome %0d wait %0d",
                       want.outcome, want.wait_us, got.outcome, got.wait_us);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        bucket_serve(command_t'(s_tuser), s_tdata[47:0], s_tdata[79:48], verdict);
        pending_verdicts.push_back(verdict);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result receiver with random stalls and an on-demand long hold-off
  initial begin
    int unsigned gap;
    forever begin
      gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_off_req) begin
        gap          = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_word(input command_t cmd, input logic [47:0] now, input logic [31:0] req);
    int unsigned gap;
    begin
      gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tuser  <= cmd;
      s_tdata  <= {req, now};
      do @(posedge clk); while (!s_tready);
    end
  endtask

  // drop the request stream, let every verdict come back, then let the block go idle
  task automatic settle_block();
    begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      case (idx)
        REG_MAX_RATE:        lim_rate     = value[RATE_W-1:0];
        REG_MAX_PERMITS:     lim_cap      = value[PERMIT_W-1:0];
        REG_PERMIT_INTERVAL: lim_interval = value[IVAL_W-1:0];
        default: ;
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task automatic test_refill_and_debt();
    begin
      send_word(CMD_ACQUIRE,  48'd0,    32'd0);
      send_word(CMD_ACQUIRE,  48'd1000, 32'd1);
      send_word(CMD_ACQUIRE,  48'd1000, 32'd5);
      send_word(CMD_ACQUIRE,  48'd2000, 32'd1);
      send_word(CMD_ROLLBACK, 48'd0,    32'd500);
      send_word(CMD_ACQUIRE,  48'd2000, 32'd100);
      send_word(CMD_ACQUIRE,  48'd7000, 32'd5000);
      settle_block();
    end
  endtask

  // with no rate headroom even a zero deficit is refused
  task automatic test_zero_rate();
    begin
      write_reg(REG_MAX_RATE, 36'd0);
      write_reg(REG_PERMIT_INTERVAL, 36'd655360);
      send_word(CMD_ROLLBACK, 48'd0, 32'd3);
      send_word(CMD_ACQUIRE,  48'd0, 32'd3);
      send_word(CMD_ACQUIRE,  48'd0, 32'd2);
      settle_block();
    end
  endtask

  task automatic test_rate_extremes();
    begin
      write_reg(REG_MAX_RATE, 36'hF_FFFF);
      write_reg(REG_PERMIT_INTERVAL, 36'd65536);
      send_word(CMD_ACQUIRE, 48'd100000,  32'd1000000);
      send_word(CMD_ACQUIRE, 48'd3000000, 32'd1048575);
      settle_block();
      write_reg(REG_MAX_RATE, 36'd1);
      send_word(CMD_ACQUIRE, 48'd5000000, 32'd4000);
      settle_block();
    end
  endtask

  // stored permits above a newly lowered cap get clipped on refill or rollback
  task automatic test_lowered_cap();
    begin
      write_reg(REG_MAX_RATE, 36'd1000);
      write_reg(REG_MAX_PERMITS, 36'hFFFF_FFFF);
      send_word(CMD_ROLLBACK, 48'd0, 32'd900000);
      settle_block();
      write_reg(REG_MAX_PERMITS, 36'd10);
      send_word(CMD_ROLLBACK, 48'd0, 32'd0);
      settle_block();
      send_word(CMD_ROLLBACK, 48'd0, 32'd900000);
      settle_block();
      write_reg(REG_MAX_PERMITS, 36'd0);
      send_word(CMD_ACQUIRE, 48'd6000000, 32'd10);
      settle_block();
    end
  endtask

  task automatic test_zero_interval();
    begin
      write_reg(REG_MAX_PERMITS, 36'hFFFF_FFFF);
      write_reg(REG_PERMIT_INTERVAL, 36'd0);
      send_word(CMD_ACQUIRE, 48'd7000000, 32'hFFFF_FFFF);
      settle_block();
      write_reg(REG_PERMIT_INTERVAL, 36'd1);
      send_word(CMD_ACQUIRE, 48'd7000010, 32'd5);
      settle_block();
    end
  endtask

  task automatic pick_phase_config();
    logic [CFG_DATA_W-1:0] v;
    begin
      case ($urandom_range(0, 7))
        0:       v = 36'd0;
        1:       v = 36'd1;
        5:       v = 36'd1000;
        6:       v = 36'hF_FFFF;
        7:       v = $urandom_range(33, 5000);
        default: v = $urandom_range(2, 32);
      endcase
      write_reg(REG_MAX_RATE, v);
      case ($urandom_range(0, 7))
        0:       v = 36'd0;
        1:       v = $urandom_range(1, 8);
        5:       v = 36'd1000;
        6:       v = 36'hFFFF_FFFF;
        7:       v = $urandom_range(1, 64);
        default: v = $urandom_range(16, 2000);
      endcase
      write_reg(REG_MAX_PERMITS, v);
      case ($urandom_range(0, 7))
        0:       v = 36'd0;
        1:       v = 36'd1;
        2:       v = $urandom_range(1, 65535);
        6:       v = $urandom_range(65536, 1 << 26);
        7:       v = 36'd65536000;
        default: v = 36'd65536 * $urandom_range(1, 64);
      endcase
      write_reg(REG_PERMIT_INTERVAL, v);
    end
  endtask

  // timed request sequence: mostly acquires at a moving clock, plus noise
  task automatic send_timed_word();
    int unsigned kind, iv_us, span, back;
    logic [63:0] wide;
    begin
      kind  = $urandom_range(0, 99);
      iv_us = lim_interval[IVAL_W-1:FRAC_W];
      span  = (lim_rate > 2000) ? 4000 : 2 * lim_rate + 8;
      if (bkt_time > {16'd0, seq_time} && $urandom_range(0, 3) == 0)
        seq_time = bkt_time[47:0];
      seq_time = seq_time + $urandom_range(0, 3 * iv_us + 4);
      wide = {$urandom(), $urandom()};
      if (kind < 10) begin
        // rollback ignores the time field, so it carries the full range
        send_word(CMD_ROLLBACK, wide[47:0], $urandom_range(0, 20));
      end else if (kind < 14) begin
        send_word(CMD_ROLLBACK, wide[47:0], $urandom());
      end else if (kind < 88) begin
        send_word(CMD_ACQUIRE, seq_time, $urandom_range(0, span));
      end else if (kind < 94) begin
        back = $urandom_range(0, 2000);
        send_word(CMD_ACQUIRE, (seq_time > back) ? seq_time - back : 48'd0,
                  $urandom_range(0, span));
      end else begin
        send_word(CMD_ACQUIRE, seq_time, $urandom());
      end
    end
  endtask

  task automatic test_random_traffic();
    begin
      for (int p = 0; p < RANDOM_PHASES; p++) begin
        pick_phase_config();
        fast_mode = (p == 3);
        for (int i = 0; i < PHASE_WORDS; i++) send_timed_word();
        settle_block();
        fast_mode = 1'b0;
      end
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_output_stall();
    begin
      write_reg(REG_MAX_RATE, 36'd16);
      write_reg(REG_MAX_PERMITS, 36'd32);
      write_reg(REG_PERMIT_INTERVAL, 36'd131072);
      hold_off_req = 1'b1;
      fast_mode    = 1'b1;
      for (int i = 0; i < STALL_WORDS; i++) send_timed_word();
      fast_mode = 1'b0;
      settle_block();
    end
  endtask

  // pushes the update time to its ceiling for good, so it runs last
  task automatic test_time_saturation();
    begin
      write_reg(REG_MAX_RATE, 36'd1000000);
      write_reg(REG_MAX_PERMITS, 36'd1000);
      write_reg(REG_PERMIT_INTERVAL, 36'hF_FFFF_FFFF);
      send_word(CMD_ACQUIRE,  TIME_MAX - 48'd100,     32'd1000);
      send_word(CMD_ROLLBACK, TIME_MAX - 48'd100,     32'd1000);
      send_word(CMD_ACQUIRE,  TIME_MAX - 48'd100,     32'd1500);
      send_word(CMD_ACQUIRE,  TIME_MAX - 48'd5000000, 32'd0);
      send_word(CMD_ACQUIRE,  TIME_MAX,               32'hFFFF_FFFF);
      settle_block();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_refill_and_debt();
    test_zero_rate();
    test_rate_extremes();
    test_lowered_cap();
    test_zero_interval();
    test_random_traffic();
    test_output_stall();
    test_time_saturation();
    if (pending_verdicts.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
